// File: rtl/olist_pkg.sv
// Shared codes, widths and cell control for the ordered list engine.
package olist_pkg;

  localparam int unsigned FuncW    = 3;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CapW     = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH_BACK  = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_POP_BACK   = 3'd2,
    FUNC_POP_FRONT  = 3'd3,
    FUNC_INSERT     = 3'd4,
    FUNC_REMOVE     = 3'd5
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOCK_ENABLE    = 1'd0,
    REG_CAPACITY_LIMIT = 1'd1
  } reg_idx_e;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic eval;      // latch per-cell hit flags
    logic by_value;  // hit on stored word equal to key, else on index == target
    logic ins;       // commit an insertion: target loads key, cells above shift up
    logic del;       // commit a removal: cells at/after first hit shift down
  } cell_ctrl_t;

endpackage

// File: rtl/olist_cell.sv
// One storage cell of the list: holds a word, flags hits, shifts to/from neighbors.
module olist_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned TW         = 7,
  parameter int unsigned IDX        = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  olist_pkg::cell_ctrl_t  ctrl_i,
  input  logic [DATA_WIDTH-1:0]  key_i,
  input  logic [TW-1:0]          tgt_i,
  input  logic [TW-1:0]          count_i,
  input  logic                   ge_i,
  input  logic [DATA_WIDTH-1:0]  prev_data_i,
  input  logic [DATA_WIDTH-1:0]  next_data_i,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic                   eq_o
);

  localparam logic [TW-1:0] MyIdx = TW'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  eq_q, eq_d;
  logic                  gt_q, gt_d;

  always_comb begin
    eq_d = eq_q;
    gt_d = gt_q;
    if (ctrl_i.eval) begin
      if (ctrl_i.by_value) begin
        eq_d = (data_q == key_i) && (MyIdx < count_i);
      end else begin
        eq_d = (MyIdx == tgt_i);
      end
      gt_d = (MyIdx > tgt_i);
    end
  end

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (eq_q) begin
        data_d = key_i;
      end else if (gt_q) begin
        data_d = prev_data_i;
      end
    end else if (ctrl_i.del && ge_i) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_q <= 1'b0;
      gt_q <= 1'b0;
    end else begin
      eq_q <= eq_d;
      gt_q <= gt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign eq_o   = eq_q;

endmodule

// File: rtl/ordered_list_engine.sv
// Ordered list engine: a row of DEPTH shifting cells plus a small sequencer.
// Each transaction has two steps: one to latch per-cell compares, one to shift.
// The shift waits while a held result is stalled; the result is registered and shows
// the cycle after the shift, and the next item is taken while it waits.
// Reset clears count, sequencer, lock and out_valid, sets cap to 64; cell words unknown.
module ordered_list_engine #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [olist_pkg::FuncW-1:0]    func_i,
  input  logic [DATA_WIDTH-1:0]          value_i,
  input  logic [olist_pkg::PosW-1:0]     position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [olist_pkg::StatusW-1:0]  status_o,
  output logic [DATA_WIDTH-1:0]          out_value_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [olist_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [olist_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned TW = (CW > olist_pkg::PosW) ? CW : olist_pkg::PosW;
  localparam int unsigned LW = (CW > olist_pkg::CapW) ? CW : olist_pkg::CapW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_e;

  state_e                      state_q;
  logic [CW-1:0]               count_q, count_d;
  logic                        lock_q;
  logic [olist_pkg::CapW-1:0]  cap_q;
  logic [olist_pkg::FuncW-1:0] func_q;
  logic [DATA_WIDTH-1:0]       key_q;
  logic [olist_pkg::PosW-1:0]  pos_q;

  logic                        out_valid_q;
  logic [olist_pkg::StatusW-1:0] status_q, status_d;
  logic [DATA_WIDTH-1:0]       out_value_q, out_value_d;
  logic [CW-1:0]               out_count_q;

  olist_pkg::cell_ctrl_t       ctrl;
  logic [TW-1:0]               tgt;
  logic [TW-1:0]               count_t;
  logic [TW-1:0]               pos_t;
  logic [DEPTH-1:0]            eq_vec, lowest, ge_vec;
  logic [DATA_WIDTH-1:0]       cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]       sel_data;
  logic [LW-1:0]               limit, count_l, cap_l;
  logic                        found, full, key_zero;
  logic                        can_commit, accept, do_ins, do_del;

  assign cfg_ready_o = 1'b1;

  assign can_commit = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_APPLY) && can_commit));
  assign accept     = in_valid_i && !in_stall_o;

  assign count_t  = TW'(count_q);
  assign pos_t    = TW'(pos_q);
  assign count_l  = LW'(count_q);
  assign cap_l    = LW'(cap_q);
  assign limit    = (lock_q && (cap_l < LW'(DEPTH))) ? cap_l : LW'(DEPTH);
  assign full     = (count_l >= limit);
  assign key_zero = (key_q == '0);

  // Target index: insertion slot, or the slot a pop takes from.
  always_comb begin
    case (func_q)
      olist_pkg::FUNC_PUSH_BACK:  tgt = count_t;
      olist_pkg::FUNC_PUSH_FRONT: tgt = '0;
      olist_pkg::FUNC_INSERT:     tgt = (pos_t < count_t) ? pos_t : count_t;
      olist_pkg::FUNC_POP_BACK:   tgt = count_t - TW'(1);
      default:                    tgt = '0;
    endcase
  end

  // First hit and everything at or above it.
  assign lowest = eq_vec & (~eq_vec + DEPTH'(1));
  assign ge_vec = ~(lowest - DEPTH'(1));
  assign found  = |eq_vec;

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_data = sel_data | (cell_data[i] & {DATA_WIDTH{lowest[i]}});
    end
  end

  // Outcome of the operation held in the request registers.
  always_comb begin
    status_d    = olist_pkg::ST_OK;
    out_value_d = '0;
    count_d     = count_q;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    case (func_q)
      olist_pkg::FUNC_PUSH_BACK, olist_pkg::FUNC_PUSH_FRONT, olist_pkg::FUNC_INSERT: begin
        if (key_zero) begin
          status_d = olist_pkg::ST_INVALID;
        end else if (full) begin
          status_d = olist_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      olist_pkg::FUNC_POP_BACK, olist_pkg::FUNC_POP_FRONT: begin
        if (count_q == '0) begin
          status_d = olist_pkg::ST_EMPTY;
        end else begin
          do_del      = 1'b1;
          out_value_d = sel_data;
          count_d     = count_q - CW'(1);
        end
      end
      olist_pkg::FUNC_REMOVE: begin
        if (key_zero) begin
          status_d = olist_pkg::ST_INVALID;
        end else if (!found) begin
          status_d = olist_pkg::ST_NOT_FOUND;
        end else begin
          do_del  = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      default: status_d = olist_pkg::ST_INVALID;
    endcase
  end

  always_comb begin
    ctrl.eval     = (state_q == S_EVAL);
    ctrl.by_value = (func_q == olist_pkg::FUNC_REMOVE);
    ctrl.ins      = (state_q == S_APPLY) && can_commit && do_ins;
    ctrl.del      = (state_q == S_APPLY) && can_commit && do_del;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data, next_data;
    if (g == 0) begin : g_first
      assign prev_data = key_q;
    end else begin : g_mid
      assign prev_data = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_data = cell_data[g];
    end else begin : g_body
      assign next_data = cell_data[g+1];
    end

    olist_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .TW         (TW),
      .IDX        (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .key_i       (key_q),
      .tgt_i       (tgt),
      .count_i     (count_t),
      .ge_i        (ge_vec[g]),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (cell_data[g]),
      .eq_o        (eq_vec[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lock_q      <= 1'b0;
      cap_q       <= olist_pkg::CapW'(64);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          olist_pkg::REG_LOCK_ENABLE:    lock_q <= cfg_data_i[0];
          olist_pkg::REG_CAPACITY_LIMIT: cap_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: state_q <= S_APPLY;
        S_APPLY: begin
          if (can_commit) begin
            count_q     <= count_d;
            out_valid_q <= 1'b1;
            state_q     <= accept ? S_EVAL : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      key_q  <= value_i;
      pos_q  <= position_i;
    end
    if ((state_q == S_APPLY) && can_commit) begin
      status_q    <= status_d;
      out_value_q <= out_value_d;
      out_count_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_value_o = out_value_q;
  assign count_o     = out_count_q;

endmodule
